/* hw/rtl/dtt_pkg.sv */
// Package: shared types, codes and constants of the deadline timer table.
`timescale 1ns / 1ps
package dtt_pkg;

   localparam int SLOTS_DEF     = 16;
   localparam int TIME_BITS_DEF = 32;

   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_REG  = 2'd1;
   localparam logic [1:0] REQ_COND = 2'd2;

   localparam logic [1:0] KIND_ONESHOT = 2'd0;
   localparam logic [1:0] KIND_PERIOD  = 2'd1;
   localparam logic [1:0] KIND_BOUNDED = 2'd2;
   localparam logic [1:0] KIND_COND    = 2'd3;

   localparam logic [2:0] ST_REGISTERED = 3'd0;
   localparam logic [2:0] ST_FIRED      = 3'd1;
   localparam logic [2:0] ST_FULL       = 3'd2;
   localparam logic [2:0] ST_ZERO_PER   = 3'd3;
   localparam logic [2:0] ST_COND_SET   = 3'd4;
   localparam logic [2:0] ST_NO_TIMER   = 3'd5;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [3:0]  slot;
      logic [1:0]  timer_kind;
      logic [31:0] time_point;
      logic [31:0] period;
      logic        condition;
   } req_type_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  slot_id;
      logic [31:0] fire_time;
      logic [1:0]  fired_kind;
      logic        last;
   } rsp_type;

endpackage

/* hw/rtl/dtt_cell.sv */
// One timer slot: holds an entry and passes a token and a free-slot mark along the row.
`timescale 1ns / 1ps
module dtt_cell #(
   parameter int TIME_BITS = dtt_pkg::TIME_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,       // new item: clear the token and free-slot mark at this cell
   input  logic                 tok_in,      // scan token arrives
   input  logic [1:0]           op,          // REQ_TICK / REQ_REG / REQ_COND
   input  logic [TIME_BITS-1:0] now,
   input  logic                 addr_hit,    // set-condition addresses this cell
   input  logic                 found_in,    // a free slot already taken upstream
   input  logic [1:0]           kind_w,
   input  logic [TIME_BITS-1:0] tp_w,
   input  logic [TIME_BITS-1:0] per_w,
   input  logic                 cond_w,
   output logic                 tok_out,
   output logic                 found_out,
   output logic                 hit,         // this cell yields a result now
   output logic                 valid,
   output logic [1:0]           kind,
   output logic [TIME_BITS-1:0] deadline
);
   import dtt_pkg::*;

   logic                 valid_ff, cond_ff;
   logic [1:0]           kind_ff;
   logic [TIME_BITS-1:0] dl_ff, per_ff, thr_ff;
   logic                 tok_ff;
   logic                 found_ff;
   logic                 take;
   logic                 retire;
   logic [TIME_BITS:0]   next;
   logic                 ovf;

   assign next = {1'b0, dl_ff} + {1'b0, per_ff};
   assign ovf  = next[TIME_BITS];

   always_comb begin
      take = 1'b0;
      hit  = 1'b0;
      unique case (op)
         REQ_TICK: hit = tok_in && valid_ff && (dl_ff <= now);
         // a zero period on any kind but one-shot is refused, so take nothing
         REQ_REG:  take = tok_in && !valid_ff && !found_in &&
                          !(kind_w != KIND_ONESHOT && per_w == '0);
         REQ_COND: hit = tok_in && addr_hit && valid_ff;
         default:  ;
      endcase
      retire = (kind_ff == KIND_ONESHOT) || (kind_ff == KIND_COND && !cond_ff) || ovf ||
               (kind_ff == KIND_BOUNDED && thr_ff <= next[TIME_BITS-1:0]);
   end

   assign found_out = found_ff;
   assign tok_out   = tok_ff;
   assign valid     = valid_ff;
   assign kind      = kind_ff;
   assign deadline  = dl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in && !clear;
         // hold the free-slot mark for the rest of the scan
         if (clear) found_ff <= 1'b0;
         else if (tok_in && op == REQ_REG && (found_in || !valid_ff)) found_ff <= 1'b1;
         if (take) begin
            valid_ff <= 1'b1;
            kind_ff  <= kind_w;
            per_ff   <= per_w;
            thr_ff   <= tp_w;
            cond_ff  <= cond_w;
            dl_ff    <= (kind_w == KIND_ONESHOT) ? tp_w : per_w;
         end else if (hit && op == REQ_COND) begin
            cond_ff <= cond_w;
         end else if (hit) begin
            if (retire) valid_ff <= 1'b0;
            if (!ovf) dl_ff <= next[TIME_BITS-1:0];
         end
      end
   end
endmodule

/* hw/rtl/deadline_timer_table_top.sv */
// Top level: request decode, slot row and result sequencing.
`timescale 1ns / 1ps
// A token walks the slot row one cell per clock, and every request keeps busy
// high from the accepting edge until its scan has ended. Each fire
// is held until the next fire or the end of the scan, so fire results trail
// the token; the final result of a request, marked last, shows in the first
// cycle after busy falls, and a tick that fires nothing gives none. Each result
// is shown for exactly one cycle on rsp_valid; the receiver cannot stall.
module deadline_timer_table_top #(
   parameter int SLOTS     = dtt_pkg::SLOTS_DEF,
   parameter int TIME_BITS = dtt_pkg::TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  dtt_pkg::req_type_type req_word,
   output logic                  rsp_valid,
   output dtt_pkg::rsp_type      rsp_word
);
   import dtt_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 3);
   localparam logic [TIME_BITS-1:0] TMAX = '1;

   logic                 busy_ff, busy_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   req_type_type         req_ff;
   logic [TIME_BITS-1:0] now_ff, tp_c, per_c;
   logic                 pend_ff, pend_in;   // a held result waits for a later one
   rsp_type              hold_ff, hold_in;
   rsp_type              out_ff, out_in;
   logic                 ov_ff, ov_in;

   logic [SLOTS:0] tok, found;
   logic [SLOTS-1:0] hit, vld;
   logic [1:0]           kinds [SLOTS];
   logic [TIME_BITS-1:0] dls [SLOTS];

   // snapshot of validity and addressed entry at item start
   logic [SLOTS-1:0] vld_snap;
   logic             cond_ok_ff;
   logic [1:0]       cond_kind_ff;

   // clamp 32-bit inputs to TIME_BITS
   function automatic logic [TIME_BITS-1:0] clampt(input logic [31:0] v);
      logic [63:0] w;
      w = {32'd0, v};
      clampt = (w > {{(64-TIME_BITS){1'b0}}, TMAX}) ? TMAX : w[TIME_BITS-1:0];
   endfunction

   assign tp_c  = clampt(req_ff.time_point);
   assign per_c = clampt(req_ff.period);
   assign tok[0]   = busy_ff && cnt_ff == '0;
   assign found[0] = 1'b0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_row
      dtt_cell #(.TIME_BITS(TIME_BITS)) u_cell (
         .clock(clock), .reset(reset), .clear(start && !busy_ff),
         .tok_in(tok[i]), .op(req_ff.req_type), .now(now_ff),
         .addr_hit({28'd0, req_ff.slot} == i), .found_in(found[i]),
         .kind_w(req_ff.timer_kind), .tp_w(tp_c), .per_w(per_c),
         .cond_w(req_ff.condition), .tok_out(tok[i+1]), .found_out(found[i+1]),
         .hit(hit[i]), .valid(vld[i]), .kind(kinds[i]), .deadline(dls[i])
      );
   end

   always_comb begin
      logic [IW-1:0] hs;
      logic          any;
      logic          fin;
      rsp_type       r;
      hs = '0; any = 1'b0;
      for (int i = 0; i < SLOTS; i++)
         if (hit[i]) begin hs = IW'(i); any = 1'b1; end
      busy_in = busy_ff; cnt_in = cnt_ff; pend_in = pend_ff; hold_in = hold_ff;
      ov_in = 1'b0; out_in = out_ff;
      fin = busy_ff && cnt_ff == CW'(SLOTS + 1);
      r = '0;
      if (start && !busy_ff) begin
         busy_in = 1'b1; cnt_in = '0; pend_in = 1'b0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (req_ff.req_type == REQ_TICK && any) begin
            r.status = ST_FIRED; r.slot_id = 4'(hs);
            r.fire_time = 32'(dls[hs]); r.fired_kind = kinds[hs];
            // emit prior fire, hold this one
            if (pend_ff) begin out_in = hold_ff; ov_in = 1'b1; end
            hold_in = r; pend_in = 1'b1;
         end
         if (fin) begin
            busy_in = 1'b0;
            unique case (req_ff.req_type)
               REQ_TICK: if (pend_ff) begin
                  out_in = hold_ff; out_in.last = 1'b1; ov_in = 1'b1;
               end
               REQ_REG: begin
                  r = '0; r.fired_kind = req_ff.timer_kind;
                  if (req_ff.timer_kind != KIND_ONESHOT && per_c == '0)
                     r.status = ST_ZERO_PER;
                  else if (!found[SLOTS]) r.status = ST_FULL;
                  else begin
                     r.status = ST_REGISTERED;
                     for (int i = SLOTS - 1; i >= 0; i--)
                        if (!vld_snap[i]) r.slot_id = 4'(i);
                  end
                  r.last = 1'b1; out_in = r; ov_in = 1'b1;
               end
               REQ_COND: begin
                  r = '0; r.slot_id = req_ff.slot; r.last = 1'b1;
                  if ({28'd0, req_ff.slot} < SLOTS && cond_ok_ff) begin
                     r.status = ST_COND_SET; r.fired_kind = cond_kind_ff;
                  end else r.status = ST_NO_TIMER;
                  out_in = r; ov_in = 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         vld_snap <= vld;
         cond_ok_ff <= 1'b0; cond_kind_ff <= '0;
         for (int i = 0; i < SLOTS; i++)
            if ({28'd0, req_word.slot} == i) begin
               cond_ok_ff <= vld[i]; cond_kind_ff <= kinds[i];
            end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= '0; pend_ff <= 1'b0; ov_ff <= 1'b0; now_ff <= '0;
      end else begin
         busy_ff <= busy_in; cnt_ff <= cnt_in; pend_ff <= pend_in; ov_ff <= ov_in;
         if (start && !busy_ff && req_word.req_type == REQ_TICK && now_ff != TMAX)
            now_ff <= now_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) req_ff <= req_word;
      hold_ff <= hold_in;
      out_ff  <= out_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = ov_ff;
   assign rsp_word  = out_ff;
endmodule

/* hw/rtl/dtt_checker.sv */
// Checker: port-level properties of the timer table, bound to the top level.
`timescale 1ns / 1ps
module dtt_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input dtt_pkg::rsp_type rsp_word
);
   import dtt_pkg::*;

   a_acc_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.status <= ST_NO_TIMER) else $error("bad status");
   a_fire_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != ST_FIRED |-> rsp_word.fire_time == '0)
      else $error("fire_time on non-fire");
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy && !$past(busy) |-> !rsp_valid) else $error("result while idle");
endmodule

bind deadline_timer_table_top dtt_checker u_dtt_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_word(rsp_word)
);
